### sv/tlrs_pkg.sv
// Shared types, constants and stamp widening functions of the timestamp log range store.
package tlrs_pkg;

    localparam int unsigned CAPACITY_DEF = 64;
    localparam int unsigned STAMP_W      = 40;
    localparam int unsigned ID_W         = 32;
    localparam int unsigned GRAN_W       = 3;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned IN_DATA_W    = 120;

    typedef logic [STAMP_W-1:0]  stamp_t;
    typedef logic [ID_W-1:0]     id_t;
    typedef logic [GRAN_W-1:0]   gran_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_MATCH  = 2'd0;
    localparam status_t ST_NONE   = 2'd1;
    localparam status_t ST_STORED = 2'd2;
    localparam status_t ST_FULL   = 2'd3;

    localparam logic REQ_INSERT   = 1'b0;
    localparam logic REQ_RETRIEVE = 1'b1;

    localparam gran_t G_YEAR   = 3'd0;
    localparam gran_t G_MONTH  = 3'd1;
    localparam gran_t G_DAY    = 3'd2;
    localparam gran_t G_HOUR   = 3'd3;
    localparam gran_t G_MINUTE = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   rot;
        stamp_t stamp;
        id_t    id;
    } cell_ctrl_t;

    function automatic stamp_t pk(input int unsigned mo, input int unsigned dd,
                                  input int unsigned hh, input int unsigned mi,
                                  input int unsigned ss);
        stamp_t r;
        r = (stamp_t'(mo) << 22) | (stamp_t'(dd) << 17) | (stamp_t'(hh) << 12)
            | (stamp_t'(mi) << 6) | stamp_t'(ss);
        return r;
    endfunction

    function automatic stamp_t widen_start(input stamp_t s, input gran_t g);
        stamp_t r;
        case (g)
            G_YEAR:   r = (s & 40'hFFFC000000) | pk(1, 1, 0, 0, 0);
            G_MONTH:  r = (s & 40'hFFFFC00000) | pk(0, 1, 0, 0, 0);
            G_DAY:    r = s & 40'hFFFFFE0000;
            G_HOUR:   r = s & 40'hFFFFFFF000;
            G_MINUTE: r = s & 40'hFFFFFFFFC0;
            default:  r = s;
        endcase
        return r;
    endfunction

    function automatic stamp_t widen_end(input stamp_t s, input gran_t g);
        stamp_t r;
        case (g)
            G_YEAR:   r = (s & 40'hFFFC000000) | pk(12, 31, 23, 59, 59);
            G_MONTH:  r = (s & 40'hFFFFC00000) | pk(0, 31, 23, 59, 59);
            G_DAY:    r = (s & 40'hFFFFFE0000) | pk(0, 0, 23, 59, 59);
            G_HOUR:   r = (s & 40'hFFFFFFF000) | pk(0, 0, 0, 59, 59);
            G_MINUTE: r = (s & 40'hFFFFFFFFC0) | pk(0, 0, 0, 0, 59);
            default:  r = s;
        endcase
        return r;
    endfunction

endpackage

### sv/timestamp_log_range_store.sv
// Top level of the timestamp log range store: cell chain, scan sequencer and output register.
//
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; tuser[0] selects insert (0) or
// range retrieve (1). Results leave on m_tvalid/m_tready/m_tdata/m_tuser/m_tlast, with the
// status code in m_tuser and m_tlast on the final result of each input item.
// On an insert every cell compares its stamp with the new one and the chain
// shifts right of the insertion point, so the stored or store-full result is presented in
// the cycle after acceptance; a new item can be taken in that cycle if m_tready is high.
// A retrieve rotates the whole ring of CAPACITY cells once, examining the cell at the head
// each cycle that the result side does not stall, then loads the final result in the
// finish state and returns to idle to accept the next item. One match is held back so
// the final match can carry tlast; the last result is loaded after the rotation ends.
// A stall on the result side freezes the rotation and holds the result register; no input
// item is accepted while a result waits and cannot move.
// Reset clears the entry count, the sequencer and the output valid; stored stamps and ids
// are not cleared and are never read before they are written.
module timestamp_log_range_store #(
    parameter int unsigned CAPACITY = tlrs_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: log_id[31:0], stamp[71:32], end_stamp[111:72],
    // granularity[114:112], zero padding.
    input  logic [tlrs_pkg::IN_DATA_W-1:0] s_tdata,
    // Fields from bit 0: req_type.
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: result_id[31:0].
    output logic [tlrs_pkg::ID_W-1:0]     m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [tlrs_pkg::STATUS_W-1:0] m_tuser,
    output logic                          m_tlast
);

    localparam int unsigned IDX_W   = $clog2(CAPACITY);
    localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

    tlrs_pkg::id_t    in_id;
    tlrs_pkg::stamp_t in_stamp;
    tlrs_pkg::stamp_t in_end;
    tlrs_pkg::gran_t  in_gran;

    assign in_id    = s_tdata[31:0];
    assign in_stamp = s_tdata[71:32];
    assign in_end   = s_tdata[111:72];
    assign in_gran  = s_tdata[114:112];

    tlrs_pkg::state_t     state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic                 pend_valid_reg, pend_valid_next;
    tlrs_pkg::id_t        pend_id_reg;
    logic                 pend_load;
    tlrs_pkg::stamp_t     lo_reg, hi_reg;
    logic                 capture;

    logic                 out_valid_reg;
    tlrs_pkg::id_t        out_id_reg, out_id_next;
    tlrs_pkg::status_t    out_status_reg, out_status_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_load;
    logic                 slot_free;

    tlrs_pkg::cell_ctrl_t ctrl;
    logic                 full;
    logic                 head_match;

    tlrs_pkg::stamp_t     cell_stamp [CAPACITY];
    tlrs_pkg::id_t        cell_id    [CAPACITY];
    logic                 cell_gt    [CAPACITY];

    assign slot_free = !out_valid_reg || m_tready;
    assign full      = (count_reg == COUNT_W'(CAPACITY));
    assign head_match = (COUNT_W'(scan_reg) < count_reg)
                        && (cell_stamp[0] >= lo_reg) && (cell_stamp[0] <= hi_reg);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam int unsigned RIGHT = (gi + 1) % CAPACITY;
            logic             valid_own;
            logic             valid_left;
            logic             gt_left;
            tlrs_pkg::stamp_t left_stamp;
            tlrs_pkg::id_t    left_id;

            assign valid_own = (COUNT_W'(gi) < count_reg);
            if (gi == 0)
            begin : g_head
                assign valid_left = 1'b1;
                assign gt_left    = 1'b0;
                assign left_stamp = ctrl.stamp;
                assign left_id    = ctrl.id;
            end
            else
            begin : g_body
                assign valid_left = (COUNT_W'(gi - 1) < count_reg);
                assign gt_left    = cell_gt[gi-1];
                assign left_stamp = cell_stamp[gi-1];
                assign left_id    = cell_id[gi-1];
            end

            tlrs_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid_own   (valid_own),
                .valid_left  (valid_left),
                .gt_left     (gt_left),
                .left_stamp  (left_stamp),
                .left_id     (left_id),
                .right_stamp (cell_stamp[RIGHT]),
                .right_id    (cell_id[RIGHT]),
                .stamp       (cell_stamp[gi]),
                .id          (cell_id[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_load       = 1'b0;
        capture         = 1'b0;
        out_load        = 1'b0;
        out_id_next     = '0;
        out_status_next = tlrs_pkg::ST_STORED;
        out_last_next   = 1'b1;
        s_tready        = 1'b0;
        ctrl.ins        = 1'b0;
        ctrl.rot        = 1'b0;
        ctrl.stamp      = in_stamp;
        ctrl.id         = in_id;

        case (state_reg)
            tlrs_pkg::S_IDLE:
            begin
                s_tready = slot_free;
                if (s_tvalid && slot_free)
                begin
                    if (s_tuser == tlrs_pkg::REQ_INSERT)
                    begin
                        out_load = 1'b1;
                        if (full)
                        begin
                            out_status_next = tlrs_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.ins   = 1'b1;
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        capture         = 1'b1;
                        scan_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = tlrs_pkg::S_SCAN;
                    end
                end
            end
            tlrs_pkg::S_SCAN:
            begin
                if (slot_free)
                begin
                    ctrl.rot = 1'b1;
                    if (head_match)
                    begin
                        // A newer match exists, so the held one is not the last.
                        if (pend_valid_reg)
                        begin
                            out_load        = 1'b1;
                            out_id_next     = pend_id_reg;
                            out_status_next = tlrs_pkg::ST_MATCH;
                            out_last_next   = 1'b0;
                        end
                        pend_load       = 1'b1;
                        pend_valid_next = 1'b1;
                    end
                    if (scan_reg == IDX_W'(CAPACITY - 1))
                    begin
                        state_next = tlrs_pkg::S_FINISH;
                    end
                    else
                    begin
                        scan_next = scan_reg + IDX_W'(1);
                    end
                end
            end
            tlrs_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_id_next     = pend_id_reg;
                        out_status_next = tlrs_pkg::ST_MATCH;
                    end
                    else
                    begin
                        out_status_next = tlrs_pkg::ST_NONE;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = tlrs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlrs_pkg::S_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            lo_reg <= tlrs_pkg::widen_start(in_stamp, in_gran);
            hi_reg <= tlrs_pkg::widen_end(in_end, in_gran);
        end
        if (pend_load)
        begin
            pend_id_reg <= cell_id[0];
        end
        if (out_load)
        begin
            out_id_reg     <= out_id_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

### sv/tlrs_cell.sv
// One cell of the sorted entry chain: holds a stamp and an id, shifts on insert or rotates on scan.
module tlrs_cell (
    input  logic                   clk,
    input  tlrs_pkg::cell_ctrl_t   ctrl,
    input  logic                   valid_own,
    input  logic                   valid_left,
    input  logic                   gt_left,
    input  tlrs_pkg::stamp_t       left_stamp,
    input  tlrs_pkg::id_t          left_id,
    input  tlrs_pkg::stamp_t       right_stamp,
    input  tlrs_pkg::id_t          right_id,
    output tlrs_pkg::stamp_t       stamp,
    output tlrs_pkg::id_t          id,
    output logic                   gt
);

    tlrs_pkg::stamp_t stamp_reg;
    tlrs_pkg::id_t    id_reg;
    logic             take_left;
    logic             take_new;

    assign gt = valid_own && (stamp_reg > ctrl.stamp);

    // The chain is sorted, so gt is false before the insertion point and true from it up to the last valid entry.
    assign take_left = gt_left;
    assign take_new  = !gt_left && (gt || (!valid_own && valid_left));

    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            if (take_left)
            begin
                stamp_reg <= left_stamp;
                id_reg    <= left_id;
            end
            else if (take_new)
            begin
                stamp_reg <= ctrl.stamp;
                id_reg    <= ctrl.id;
            end
        end
        else if (ctrl.rot)
        begin
            stamp_reg <= right_stamp;
            id_reg    <= right_id;
        end
    end

    assign stamp = stamp_reg;
    assign id    = id_reg;

endmodule

### sv/tlrs_checker.sv
// Port-level assertions for the timestamp log range store and their bind to the top level.
module tlrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [tlrs_pkg::IN_DATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tlrs_pkg::ID_W-1:0]     m_tdata,
    input logic [tlrs_pkg::STATUS_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // Once reset has been seen at a clock edge, no result is shown in the next cycle.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // No new item is taken while a result waits.
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("item accepted while result stalled");

    // An insert is answered in the next cycle by a single stored or full result.
    a_insert_reply: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == tlrs_pkg::REQ_INSERT)
        |=> m_tvalid && m_tlast && (m_tdata == '0)
        && ((m_tuser == tlrs_pkg::ST_STORED) || (m_tuser == tlrs_pkg::ST_FULL)))
        else $error("insert reply missing or malformed");

    // Every result other than a match is a lone final result with a zero id.
    a_nonmatch_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != tlrs_pkg::ST_MATCH) |-> m_tlast && (m_tdata == '0))
        else $error("non-match result not final or id not zero");

endmodule

bind timestamp_log_range_store tlrs_checker u_tlrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
